>>> design/itoa_pkg.sv
// Shared types, codes and character constants for the integer-to-ASCII formatter.
// No dependencies; every other design file but itoa_ifs imports this package.
package itoa_pkg;

    typedef logic [2:0] op_code_t;

    localparam op_code_t OP_SDEC = 3'd0;
    localparam op_code_t OP_UDEC = 3'd1;
    localparam op_code_t OP_OCT  = 3'd2;
    localparam op_code_t OP_HEXU = 3'd3;
    localparam op_code_t OP_HEXL = 3'd4;
    localparam op_code_t OP_PTR  = 3'd5;

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_X       = 8'd120;
    localparam logic [7:0] LOWER_BIAS = 8'd87;
    localparam logic [7:0] UPPER_BIAS = 8'd55;

    localparam logic [4:0] DEC_DIGITS = 5'd10;
    localparam logic [4:0] OCT_DIGITS = 5'd11;
    localparam logic [4:0] HEX_DIGITS = 5'd8;
    localparam logic [4:0] PTR_DIGITS = 5'd16;
    localparam logic [4:0] DABBLE_LAST = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_TRIM,
        ST_PREFIX,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_DABBLE,
        CMD_SHIFT
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       cnt_one;
        logic       dabble_last;
    } dp_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] dw;
        dw = {4'b0000, d};
        if (d < 4'd10)
            return dw + CH_ZERO;
        else
            return dw + (lower ? LOWER_BIAS : UPPER_BIAS);
    endfunction

endpackage

>>> design/itoa_ifs.sv
// Valid/ready channel interfaces for the formatter: request (operation, value)
// and response (character, last). Depends on nothing.
interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> design/integer_to_ascii_formatter_unit.sv
// Top level of the integer-to-ASCII formatter: sequencer plus shared digit unit.
// Depends on itoa_pkg, itoa_ifs, itoa_digit_unit and itoa_ctrl.
//
//   channel | dir | payload               | handshake
//   din     | in  | operation[2:0], value | valid/ready
//   dout    | out | character[7:0], last  | valid/ready
//
// Per value: intake, then 32 double-dabble steps (decimal kinds only),
// then trim, dropping one leading zero per cycle and then leaving trim,
// then the characters are sent, one per cycle unless dout stalls.
// din.ready is high only between values; the output register lets the next
// value start while the final character is still waiting. Reset clears all
// control state; dout stalls hold the sequencer in its prefix and emit states.
module integer_to_ascii_formatter_unit
    import itoa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    din,
    itoa_out_if.source dout
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    itoa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout),
        .stat  (stat),
        .cmd   (cmd)
    );

    itoa_digit_unit u_digit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (din.operation),
        .value     (din.value),
        .stat      (stat)
    );

    // a valid kind starts a multi-cycle conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready && din.operation <= OP_PTR |=> !din.ready)
        else $error("intake not blocked during conversion");

    // dropped codes never produce a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready && din.operation > OP_PTR && !dout.valid |=> !dout.valid)
        else $error("beat produced for unused code");

    // a pending non-final beat means the value is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.last |-> !din.ready)
        else $error("idle with value unfinished");

endmodule

>>> design/itoa_digit_unit.sv
// Shared digit datapath: double-dabble binary-to-BCD step and digit shifter.
// Depends on itoa_pkg.
module itoa_digit_unit
    import itoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  op_code_t    operation,
    input  logic [63:0] value,
    output dp_stat_t    stat
);

    logic [63:0] work_reg, work_next;
    logic [31:0] bin_reg, bin_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [4:0]  iter_reg, iter_next;
    logic        wide_reg, wide_next;

    logic [31:0] lo;
    logic [31:0] mag;
    logic [39:0] bcd_adj;

    assign lo  = value[31:0];
    assign mag = (operation == OP_SDEC && lo[31]) ? (~lo + 32'd1) : lo;

    // add-3 correction on every BCD digit, ahead of the shift
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            if (work_reg[24 + 4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = work_reg[24 + 4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = work_reg[24 + 4*i +: 4];
        end
    end

    always_comb
    begin
        work_next = work_reg;
        bin_next  = bin_reg;
        cnt_next  = cnt_reg;
        iter_next = iter_reg;
        wide_next = wide_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
            end
            CMD_LOAD:
            begin
                iter_next = 5'd0;
                bin_next  = mag;
                unique case (operation)
                    OP_OCT:
                    begin
                        work_next = {1'b0, lo, 31'd0};
                        cnt_next  = OCT_DIGITS;
                        wide_next = 1'b0;
                    end
                    OP_HEXU, OP_HEXL:
                    begin
                        work_next = {lo, 32'd0};
                        cnt_next  = HEX_DIGITS;
                        wide_next = 1'b1;
                    end
                    OP_PTR:
                    begin
                        work_next = value;
                        cnt_next  = PTR_DIGITS;
                        wide_next = 1'b1;
                    end
                    default:
                    begin
                        work_next = 64'd0;
                        cnt_next  = DEC_DIGITS;
                        wide_next = 1'b1;
                    end
                endcase
            end
            CMD_DABBLE:
            begin
                work_next = {bcd_adj[38:0], bin_reg[31], 24'd0};
                bin_next  = {bin_reg[30:0], 1'b0};
                iter_next = iter_reg + 5'd1;
            end
            CMD_SHIFT:
            begin
                work_next = wide_reg ? {work_reg[59:0], 4'd0} : {work_reg[60:0], 3'd0};
                cnt_next  = cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            iter_reg <= 5'd0;
            wide_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            iter_reg <= iter_next;
            wide_reg <= wide_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        bin_reg  <= bin_next;
    end

    assign stat.digit       = wide_reg ? work_reg[63:60] : {1'b0, work_reg[63:61]};
    assign stat.cnt_one     = (cnt_reg == 5'd1);
    assign stat.dabble_last = (iter_reg == DABBLE_LAST);

endmodule

>>> design/itoa_ctrl.sv
// Sequencer for the formatter: item intake, conversion phases, prefix and digit
// output with the output register. Depends on itoa_pkg and itoa_ifs.
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    itoa_in_if.sink     din,
    itoa_out_if.source  dout,
    input  dp_stat_t    stat,
    output dp_cmd_t     cmd
);

    state_t     state_reg, state_next;
    op_code_t   op_reg, op_next;
    logic       neg_reg, neg_next;
    logic       pfx_reg, pfx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;

    logic       can_load;
    logic       load;
    logic [7:0] char_sel;
    logic       last_sel;
    logic       is_dec;

    assign can_load = !out_valid_reg || dout.ready;
    assign is_dec   = (din.operation == OP_SDEC) || (din.operation == OP_UDEC);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        pfx_next   = pfx_reg;
        cmd        = CMD_HOLD;
        load       = 1'b0;
        char_sel   = CH_ZERO;
        last_sel   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // codes above pointer are taken and dropped
                if (din.valid && din.operation <= OP_PTR)
                begin
                    cmd        = CMD_LOAD;
                    op_next    = din.operation;
                    neg_next   = (din.operation == OP_SDEC) && din.value[31];
                    state_next = is_dec ? ST_DABBLE : ST_TRIM;
                end
            end
            ST_DABBLE:
            begin
                cmd = CMD_DABBLE;
                if (stat.dabble_last)
                    state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                // drop leading zeros, always keep one digit
                if (!stat.cnt_one && stat.digit == 4'd0)
                    cmd = CMD_SHIFT;
                else
                begin
                    pfx_next   = 1'b0;
                    state_next = (op_reg == OP_PTR || neg_reg) ? ST_PREFIX : ST_EMIT;
                end
            end
            ST_PREFIX:
            begin
                if (can_load)
                begin
                    load = 1'b1;
                    if (op_reg == OP_PTR)
                    begin
                        char_sel = pfx_reg ? CH_X : CH_ZERO;
                        if (pfx_reg)
                            state_next = ST_EMIT;
                        else
                            pfx_next = 1'b1;
                    end
                    else
                    begin
                        char_sel   = CH_MINUS;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    load     = 1'b1;
                    char_sel = digit_char(stat.digit, op_reg == OP_HEXL || op_reg == OP_PTR);
                    last_sel = stat.cnt_one;
                    if (stat.cnt_one)
                        state_next = ST_IDLE;
                    else
                        cmd = CMD_SHIFT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SDEC;
            neg_reg       <= 1'b0;
            pfx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            neg_reg       <= neg_next;
            pfx_reg       <= pfx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_sel;
            last_reg <= last_sel;
        end
    end

    assign din.ready      = (state_reg == ST_IDLE);
    assign dout.valid     = out_valid_reg;
    assign dout.character = char_reg;
    assign dout.last      = last_reg;

endmodule
